@@ rtl/core/assert_macros.svh @@
// Assertion macros for the checker file.
// Needs nothing else; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define BQS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define BQS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/bqs_pkg.sv @@
// Shared constants, control codes and the sequencer-to-datapath struct
// for the biquad shelf filter. No dependencies.
package bqs_pkg;

    localparam int CHANNELS  = 2;
    localparam int IDX_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    localparam int SAMPLE_W  = 24;
    localparam int COEF_W    = 32;
    localparam int W_W       = 32;
    localparam int PROD_W    = 2 * COEF_W;
    localparam int ACC_W     = PROD_W + 2;
    localparam int FRAC      = 28;
    localparam int HI_W      = ACC_W - FRAC;
    localparam int CFG_IDX_W = 3;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_B0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_B1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_B2 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_A1 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_A2 = 3'd4;

    localparam logic signed [COEF_W-1:0] B0_RESET = 32'sh1000_0000;

    // Coefficient operand select
    localparam logic [2:0] COEF_B0 = 3'd0;
    localparam logic [2:0] COEF_B1 = 3'd1;
    localparam logic [2:0] COEF_B2 = 3'd2;
    localparam logic [2:0] COEF_A1 = 3'd3;
    localparam logic [2:0] COEF_A2 = 3'd4;

    // State operand select
    localparam logic [1:0] DATA_W1 = 2'd0;
    localparam logic [1:0] DATA_W2 = 2'd1;
    localparam logic [1:0] DATA_W  = 2'd2;

    // Accumulator operations
    localparam logic [2:0] ACC_HOLD   = 3'd0;
    localparam logic [2:0] ACC_LOAD_X = 3'd1;
    localparam logic [2:0] ACC_SUB    = 3'd2;
    localparam logic [2:0] ACC_START  = 3'd3;
    localparam logic [2:0] ACC_ADD    = 3'd4;

    typedef struct packed {
        logic [2:0] coef_sel;
        logic [1:0] data_sel;
        logic [2:0] acc_op;
        logic       take_w;
        logic       finish;
    } ctrl_t;

endpackage

@@ rtl/core/bqs_seq.sv @@
// Step sequencer for the biquad: walks one sample through the shared
// multiply-accumulate unit. Depends on bqs_pkg.
module bqs_seq (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    input  logic           out_hold,
    output logic           in_ready,
    output bqs_pkg::ctrl_t ctrl
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_S0   = 3'd1;
    localparam logic [2:0] ST_S1   = 3'd2;
    localparam logic [2:0] ST_S2   = 3'd3;
    localparam logic [2:0] ST_S3   = 3'd4;
    localparam logic [2:0] ST_S4   = 3'd5;
    localparam logic [2:0] ST_S5   = 3'd6;
    localparam logic [2:0] ST_S6   = 3'd7;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (in_valid) state_next = ST_S0;
            ST_S0:   state_next = ST_S1;
            ST_S1:   state_next = ST_S2;
            ST_S2:   state_next = ST_S3;
            ST_S3:   state_next = ST_S4;
            ST_S4:   state_next = ST_S5;
            ST_S5:   state_next = ST_S6;
            ST_S6:   if (!out_hold) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // w = x - a1*w1 - a2*w2, then y = b1*w1 + b2*w2 + b0*w
    always_comb
    begin
        ctrl          = '0;
        ctrl.coef_sel = bqs_pkg::COEF_B0;
        ctrl.data_sel = bqs_pkg::DATA_W;
        ctrl.acc_op   = bqs_pkg::ACC_HOLD;
        unique case (state_reg)
            ST_S0:
            begin
                ctrl.coef_sel = bqs_pkg::COEF_A1;
                ctrl.data_sel = bqs_pkg::DATA_W1;
                ctrl.acc_op   = bqs_pkg::ACC_LOAD_X;
            end
            ST_S1:
            begin
                ctrl.coef_sel = bqs_pkg::COEF_A2;
                ctrl.data_sel = bqs_pkg::DATA_W2;
                ctrl.acc_op   = bqs_pkg::ACC_SUB;
            end
            ST_S2:
            begin
                ctrl.coef_sel = bqs_pkg::COEF_B1;
                ctrl.data_sel = bqs_pkg::DATA_W1;
                ctrl.acc_op   = bqs_pkg::ACC_SUB;
            end
            ST_S3:
            begin
                ctrl.coef_sel = bqs_pkg::COEF_B2;
                ctrl.data_sel = bqs_pkg::DATA_W2;
                ctrl.acc_op   = bqs_pkg::ACC_START;
                ctrl.take_w   = 1'b1;
            end
            ST_S4:
            begin
                ctrl.coef_sel = bqs_pkg::COEF_B0;
                ctrl.data_sel = bqs_pkg::DATA_W;
                ctrl.acc_op   = bqs_pkg::ACC_ADD;
            end
            ST_S5:
            begin
                ctrl.acc_op   = bqs_pkg::ACC_ADD;
            end
            ST_S6:
            begin
                ctrl.finish   = !out_hold;
            end
            default:
            begin
                ctrl.acc_op   = bqs_pkg::ACC_HOLD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

@@ rtl/core/bqs_mac.sv @@
// Shared 32x32 multiplier with registered product, wide accumulator,
// and rounding/saturation of w and y. Depends on bqs_pkg.
module bqs_mac (
    input  logic                                 clk,
    input  bqs_pkg::ctrl_t                       ctrl,
    input  logic signed [bqs_pkg::COEF_W-1:0]    coef,
    input  logic signed [bqs_pkg::W_W-1:0]       data,
    input  logic signed [bqs_pkg::SAMPLE_W-1:0]  sample,
    output logic signed [bqs_pkg::W_W-1:0]       w,
    output logic signed [bqs_pkg::SAMPLE_W-1:0]  y
);

    localparam logic signed [bqs_pkg::ACC_W-1:0] HALF =
        bqs_pkg::ACC_W'(1) <<< (bqs_pkg::FRAC - 1);
    localparam logic signed [bqs_pkg::W_W-1:0] W_MAX =
        {1'b0, {(bqs_pkg::W_W-1){1'b1}}};
    localparam logic signed [bqs_pkg::SAMPLE_W-1:0] Y_MAX =
        {1'b0, {(bqs_pkg::SAMPLE_W-1){1'b1}}};

    logic signed [bqs_pkg::PROD_W-1:0] prod_reg;
    logic signed [bqs_pkg::PROD_W-1:0] prod_next;
    logic signed [bqs_pkg::ACC_W-1:0]  acc_reg;
    logic signed [bqs_pkg::ACC_W-1:0]  acc_next;
    logic signed [bqs_pkg::ACC_W-1:0]  prod_ext;
    logic signed [bqs_pkg::W_W-1:0]    w_reg;
    logic signed [bqs_pkg::W_W-1:0]    w_sat;
    logic [bqs_pkg::HI_W-1:0]          acc_hi;
    logic                              w_fits;
    logic                              y_fits;

    assign prod_next = coef * data;
    assign prod_ext  = bqs_pkg::ACC_W'(prod_reg);

    always_comb
    begin
        case (ctrl.acc_op)
            bqs_pkg::ACC_LOAD_X: acc_next = (bqs_pkg::ACC_W'(sample) <<< bqs_pkg::FRAC) + HALF;
            bqs_pkg::ACC_SUB:    acc_next = acc_reg - prod_ext;
            bqs_pkg::ACC_START:  acc_next = HALF + prod_ext;
            bqs_pkg::ACC_ADD:    acc_next = acc_reg + prod_ext;
            default:             acc_next = acc_reg;
        endcase
    end

    // Floor shift by the fraction width, then clamp on sign-bit agreement
    assign acc_hi = acc_reg[bqs_pkg::ACC_W-1:bqs_pkg::FRAC];
    assign w_fits = (&acc_hi[bqs_pkg::HI_W-1:bqs_pkg::W_W-1])
                  | ~(|acc_hi[bqs_pkg::HI_W-1:bqs_pkg::W_W-1]);
    assign y_fits = (&acc_hi[bqs_pkg::HI_W-1:bqs_pkg::SAMPLE_W-1])
                  | ~(|acc_hi[bqs_pkg::HI_W-1:bqs_pkg::SAMPLE_W-1]);

    assign w_sat = w_fits ? acc_hi[bqs_pkg::W_W-1:0]
                 : (acc_hi[bqs_pkg::HI_W-1] ? ~W_MAX : W_MAX);
    assign y     = y_fits ? acc_hi[bqs_pkg::SAMPLE_W-1:0]
                 : (acc_hi[bqs_pkg::HI_W-1] ? ~Y_MAX : Y_MAX);
    assign w     = w_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
        if (ctrl.take_w)
            w_reg <= w_sat;
    end

endmodule

@@ rtl/core/biquad_shelf_filter_df2.sv @@
// Multichannel direct-form-II biquad: top level with coefficient registers,
// per-channel delay state and output register. Depends on bqs_pkg, bqs_seq, bqs_mac.
//
// On acceptance the word and its channel's delay state are latched. Six steps then
// go through the single 32x32 multiplier and accumulator (five products, one
// rounding of w), and a closing step loads the output register and writes back
// the delays; only then can the next word be accepted. in_ready is
// low for the whole of that run; the output register lets the next word enter
// while a result still waits, and the last step holds while the previous result
// is not yet taken. A channel number at or above the channel count filters with
// zero state and leaves all state untouched. Coefficients are Q4.28 and may be
// written only while idle; indexes past coef_a2 are ignored.
module biquad_shelf_filter_df2 (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      cfg_we,
    input  logic [bqs_pkg::CFG_IDX_W-1:0]             cfg_index,
    input  logic [bqs_pkg::COEF_W-1:0]                cfg_data,
    input  logic                                      in_valid,
    output logic                                      in_ready,
    input  logic signed [bqs_pkg::SAMPLE_W-1:0]       sample_in,
    input  logic                                      channel_in,
    output logic                                      out_valid,
    input  logic                                      out_ready,
    output logic signed [bqs_pkg::SAMPLE_W-1:0]       sample_out,
    output logic                                      channel_out
);

    logic signed [bqs_pkg::COEF_W-1:0]   coef_b0_reg;
    logic signed [bqs_pkg::COEF_W-1:0]   coef_b1_reg;
    logic signed [bqs_pkg::COEF_W-1:0]   coef_b2_reg;
    logic signed [bqs_pkg::COEF_W-1:0]   coef_a1_reg;
    logic signed [bqs_pkg::COEF_W-1:0]   coef_a2_reg;

    logic signed [bqs_pkg::W_W-1:0]      delay_first_reg  [bqs_pkg::CHANNELS];
    logic signed [bqs_pkg::W_W-1:0]      delay_second_reg [bqs_pkg::CHANNELS];

    logic signed [bqs_pkg::SAMPLE_W-1:0] sample_reg;
    logic                                chan_reg;
    logic                                chan_ok_reg;
    logic signed [bqs_pkg::W_W-1:0]      w1_reg;
    logic signed [bqs_pkg::W_W-1:0]      w2_reg;

    logic                                out_valid_reg;
    logic                                out_valid_next;
    logic signed [bqs_pkg::SAMPLE_W-1:0] sample_out_reg;
    logic                                channel_out_reg;

    logic                                accept;
    logic                                out_hold;
    logic                                chan_ok;
    logic [bqs_pkg::IDX_W-1:0]           in_idx;
    logic [bqs_pkg::IDX_W-1:0]           st_idx;
    bqs_pkg::ctrl_t                      ctrl;
    logic signed [bqs_pkg::COEF_W-1:0]   coef_op;
    logic signed [bqs_pkg::W_W-1:0]      data_op;
    logic signed [bqs_pkg::W_W-1:0]      w;
    logic signed [bqs_pkg::SAMPLE_W-1:0] y;

    assign accept   = in_valid & in_ready;
    assign out_hold = out_valid_reg & ~out_ready;
    assign chan_ok  = (32'(channel_in) < bqs_pkg::CHANNELS);
    assign in_idx   = bqs_pkg::IDX_W'(channel_in);
    assign st_idx   = bqs_pkg::IDX_W'(chan_reg);

    bqs_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .out_hold (out_hold),
        .in_ready (in_ready),
        .ctrl     (ctrl)
    );

    always_comb
    begin
        case (ctrl.coef_sel)
            bqs_pkg::COEF_B1: coef_op = coef_b1_reg;
            bqs_pkg::COEF_B2: coef_op = coef_b2_reg;
            bqs_pkg::COEF_A1: coef_op = coef_a1_reg;
            bqs_pkg::COEF_A2: coef_op = coef_a2_reg;
            default:          coef_op = coef_b0_reg;
        endcase
        case (ctrl.data_sel)
            bqs_pkg::DATA_W1: data_op = w1_reg;
            bqs_pkg::DATA_W2: data_op = w2_reg;
            default:          data_op = w;
        endcase
    end

    bqs_mac u_mac (
        .clk    (clk),
        .ctrl   (ctrl),
        .coef   (coef_op),
        .data   (data_op),
        .sample (sample_reg),
        .w      (w),
        .y      (y)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_b0_reg <= bqs_pkg::B0_RESET;
            coef_b1_reg <= '0;
            coef_b2_reg <= '0;
            coef_a1_reg <= '0;
            coef_a2_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                bqs_pkg::REG_B0: coef_b0_reg <= cfg_data;
                bqs_pkg::REG_B1: coef_b1_reg <= cfg_data;
                bqs_pkg::REG_B2: coef_b2_reg <= cfg_data;
                bqs_pkg::REG_A1: coef_a1_reg <= cfg_data;
                bqs_pkg::REG_A2: coef_a2_reg <= cfg_data;
                default:         ;
            endcase
        end
    end

    // Latch the word and its channel state; unknown channels run on zero state
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            sample_reg  <= sample_in;
            chan_reg    <= channel_in;
            chan_ok_reg <= chan_ok;
            w1_reg      <= chan_ok ? delay_first_reg[in_idx]  : '0;
            w2_reg      <= chan_ok ? delay_second_reg[in_idx] : '0;
        end
    end

    // Advance the delay line of the channel just finished
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < bqs_pkg::CHANNELS; i++)
            begin
                delay_first_reg[i]  <= '0;
                delay_second_reg[i] <= '0;
            end
        end
        else if (ctrl.finish && chan_ok_reg)
        begin
            delay_first_reg[st_idx]  <= w;
            delay_second_reg[st_idx] <= w1_reg;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (ctrl.finish)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.finish)
        begin
            sample_out_reg  <= y;
            channel_out_reg <= chan_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign sample_out  = sample_out_reg;
    assign channel_out = channel_out_reg;

endmodule

@@ rtl/core/bqs_checker.sv @@
// Port-level checks for the biquad top level, attached by bind.
// Depends on bqs_pkg and assert_macros.svh.
`include "assert_macros.svh"

module bqs_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                in_valid,
    input logic                                in_ready,
    input logic                                out_valid,
    input logic                                out_ready,
    input logic [bqs_pkg::SAMPLE_W-1:0]        sample_out,
    input logic                                channel_out
);

    logic in_acc;
    logic out_stall;

    assign in_acc    = in_valid & in_ready;
    assign out_stall = out_valid & ~out_ready;

    `BQS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_stall, out_valid && $stable(sample_out) && $stable(channel_out), "output word changed while stalled")
    `BQS_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_acc, !in_ready, "ready right after an accepted word")
    `BQS_ASSERT_NOW(a_busy_through_run, clk, rst_n, in_acc, ##7 !in_ready, "ready before the step run could finish")
    `BQS_ASSERT_NOW(a_result_from_run, clk, rst_n, $rose(out_valid), $past(!in_ready), "result appeared with no word in flight")

endmodule

bind biquad_shelf_filter_df2 bqs_checker u_bqs_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .sample_out  (sample_out),
    .channel_out (channel_out)
);

@@ tb/biquad_shelf_filter_df2_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for biquad_shelf_filter_df2: drives sample words with random
// gaps and output stalls, predicts each filtered word in fixed point. Depends on bqs_pkg.
module biquad_shelf_filter_df2_tb;

    typedef logic signed [71:0] wide_t;

    typedef struct {
        logic signed [bqs_pkg::SAMPLE_W-1:0] sample;
        logic                                channel;
    } audio_word_t;

    localparam int    CYCLE_LIMIT = 500000;
    localparam wide_t HALF_LSB    = 72'sd1 <<< (bqs_pkg::FRAC - 1);
    localparam wide_t WSAT_HI     = 72'sd2147483647;
    localparam wide_t WSAT_LO     = -72'sd2147483648;
    localparam wide_t YSAT_HI     = 72'sd8388607;
    localparam wide_t YSAT_LO     = -72'sd8388608;

    logic                                clk = 1'b0;
    logic                                rst_n = 1'b0;
    logic                                cfg_we = 1'b0;
    logic [bqs_pkg::CFG_IDX_W-1:0]       cfg_index = '0;
    logic [bqs_pkg::COEF_W-1:0]          cfg_data = '0;
    logic                                in_valid = 1'b0;
    logic                                in_ready;
    logic signed [bqs_pkg::SAMPLE_W-1:0] sample_in = '0;
    logic                                channel_in = 1'b0;
    logic                                out_valid;
    logic                                out_ready = 1'b0;
    logic signed [bqs_pkg::SAMPLE_W-1:0] sample_out;
    logic                                channel_out;

    biquad_shelf_filter_df2 dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .sample_in  (sample_in),
        .channel_in (channel_in),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .sample_out (sample_out),
        .channel_out(channel_out)
    );

    always #1 clk = ~clk;

    // Filter copy: coefficients and per-channel delay line
    logic signed [bqs_pkg::COEF_W-1:0] ff_b0, ff_b1, ff_b2, fb_a1, fb_a2;
    logic signed [bqs_pkg::W_W-1:0]    w_z1 [bqs_pkg::CHANNELS];
    logic signed [bqs_pkg::W_W-1:0]    w_z2 [bqs_pkg::CHANNELS];

    audio_word_t pending_q[$];
    audio_word_t filtered_q[$];

    int  queued_total = 0;
    int  accepted_total = 0;
    int  checked_total = 0;
    int  error_count = 0;
    int  y_clips = 0;
    int  w_clips = 0;
    int  settings_used = 0;
    int  cycle_count = 0;
    int  gap_left = 0;
    int  stall_left = 0;
    bit  calm = 1'b0;
    audio_word_t next_word;
    audio_word_t want;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic void filter_sample(input logic signed [bqs_pkg::SAMPLE_W-1:0] x,
                                          input logic ch);
        logic signed [bqs_pkg::W_W-1:0] w1;
        logic signed [bqs_pkg::W_W-1:0] w2;
        logic signed [bqs_pkg::W_W-1:0] w;
        wide_t                          acc;
        audio_word_t                    res;
        bit                             live;
        live = int'(ch) < bqs_pkg::CHANNELS;
        w1 = live ? w_z1[ch] : '0;
        w2 = live ? w_z2[ch] : '0;
        acc = (wide_t'(x) <<< bqs_pkg::FRAC) - wide_t'(fb_a1) * wide_t'(w1)
            - wide_t'(fb_a2) * wide_t'(w2);
        acc = (acc + HALF_LSB) >>> bqs_pkg::FRAC;
        if (acc > WSAT_HI)
        begin
            acc = WSAT_HI;
            w_clips++;
        end
        else if (acc < WSAT_LO)
        begin
            acc = WSAT_LO;
            w_clips++;
        end
        w = acc[bqs_pkg::W_W-1:0];
        acc = wide_t'(ff_b0) * wide_t'(w) + wide_t'(ff_b1) * wide_t'(w1)
            + wide_t'(ff_b2) * wide_t'(w2);
        acc = (acc + HALF_LSB) >>> bqs_pkg::FRAC;
        if (acc > YSAT_HI)
        begin
            acc = YSAT_HI;
            y_clips++;
        end
        else if (acc < YSAT_LO)
        begin
            acc = YSAT_LO;
            y_clips++;
        end
        res.sample = acc[bqs_pkg::SAMPLE_W-1:0];
        res.channel = ch;
        filtered_q.push_back(res);
        if (live)
        begin
            w_z2[ch] = w1;
            w_z1[ch] = w;
        end
    endfunction

    // Sender: one word per handshake, random gaps between words
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                filter_sample(sample_in, channel_in);
                accepted_total++;
            end
            if (!in_valid || in_ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (pending_q.size() != 0)
                begin
                    next_word = pending_q.pop_front();
                    in_valid <= 1'b1;
                    sample_in <= next_word.sample;
                    channel_in <= next_word.channel;
                    gap_left = calm ? 0 : pick_gap();
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: compare each word with the oldest prediction, stall at random
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (filtered_q.size() == 0)
                begin
                    $display("%0t: unexpected word sample_out %0d channel_out %0d",
                             $time, sample_out, channel_out);
                    error_count++;
                end
                else
                begin
                    want = filtered_q.pop_front();
                    checked_total++;
                    if (sample_out !== want.sample)
                    begin
                        $display("%0t: sample_out expected %0d got %0d",
                                 $time, want.sample, sample_out);
                        error_count++;
                    end
                    if (channel_out !== want.channel)
                    begin
                        $display("%0t: channel_out expected %0d got %0d",
                                 $time, want.channel, channel_out);
                        error_count++;
                    end
                end
            end
            if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
                if (!calm && $urandom_range(0, 99) < 15)
                    stall_left = pick_gap();
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d words still expected",
                     cycle_count, filtered_q.size());
            $display("FAILURE");
            $finish;
        end
    end

    task automatic write_reg(input logic [bqs_pkg::CFG_IDX_W-1:0] idx,
                             input logic [bqs_pkg::COEF_W-1:0] value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        case (idx)
            bqs_pkg::REG_B0: ff_b0 = value;
            bqs_pkg::REG_B1: ff_b1 = value;
            bqs_pkg::REG_B2: ff_b2 = value;
            bqs_pkg::REG_A1: fb_a1 = value;
            bqs_pkg::REG_A2: fb_a2 = value;
            default: ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic load_coefs(input logic [bqs_pkg::COEF_W-1:0] b0,
                              input logic [bqs_pkg::COEF_W-1:0] b1,
                              input logic [bqs_pkg::COEF_W-1:0] b2,
                              input logic [bqs_pkg::COEF_W-1:0] a1,
                              input logic [bqs_pkg::COEF_W-1:0] a2);
        write_reg(bqs_pkg::REG_B0, b0);
        write_reg(bqs_pkg::REG_B1, b1);
        write_reg(bqs_pkg::REG_B2, b2);
        write_reg(bqs_pkg::REG_A1, a1);
        write_reg(bqs_pkg::REG_A2, a2);
        settings_used++;
    endtask

    task automatic push_word(input logic signed [bqs_pkg::SAMPLE_W-1:0] s, input logic ch);
        audio_word_t wd;
        wd.sample = s;
        wd.channel = ch;
        pending_q.push_back(wd);
        queued_total++;
    endtask

    // Hold until every queued word went in and every result came out
    task automatic wait_idle();
        do
            @(posedge clk);
        while (accepted_total != queued_total || filtered_q.size() != 0);
        repeat (10) @(posedge clk);
    endtask

    function automatic logic [bqs_pkg::COEF_W-1:0] corner_coef();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'h0000_0000;
            3: return 32'h1000_0000;
            4: return 32'hF000_0000;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic signed [bqs_pkg::SAMPLE_W-1:0] rand_sample();
        logic [31:0] r;
        r = $urandom;
        case ($urandom_range(0, 9))
            0: return r[0] ? 24'sh7F_FFFF : 24'sh80_0000;
            1: return bqs_pkg::SAMPLE_W'(int'($urandom_range(0, 511)) - 256);
            default: return r[bqs_pkg::SAMPLE_W-1:0];
        endcase
    endfunction

    initial
    begin
        int ph;
        int k;
        ff_b0 = bqs_pkg::B0_RESET;
        ff_b1 = '0;
        ff_b2 = '0;
        fb_a1 = '0;
        fb_a2 = '0;
        for (k = 0; k < bqs_pkg::CHANNELS; k++)
        begin
            w_z1[k] = '0;
            w_z2[k] = '0;
        end
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Reset coefficients pass samples straight through
        settings_used++;
        push_word(24'sh7F_FFFF, 1'b0);
        push_word(24'sh80_0000, 1'b1);
        push_word(24'sh00_0000, 1'b0);
        push_word(-24'sd1, 1'b1);
        push_word(24'sd1, 1'b0);
        push_word(24'sh55_5555, 1'b1);
        push_word(24'shAA_AAAA, 1'b0);
        wait_idle();

        // Extreme gains: w and y both run into their limits
        load_coefs(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
        write_reg(3'd5, 32'hFFFF_FFFF);
        write_reg(3'd6, 32'h0000_0000);
        write_reg(3'd7, $urandom);
        for (k = 0; k < 4; k++)
            push_word(24'sh7F_FFFF, 1'b0);
        for (k = 0; k < 3; k++)
            push_word(24'sh80_0000, 1'b1);
        push_word(24'sh00_0000, 1'b0);
        push_word(24'sd1, 1'b1);
        push_word(24'sh80_0000, 1'b0);
        wait_idle();

        load_coefs(32'h8000_0000, 32'h0000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
        push_word(24'sh80_0000, 1'b0);
        push_word(24'sh7F_FFFF, 1'b1);
        push_word(24'sh40_0000, 1'b0);
        push_word(-24'sd1, 1'b1);
        push_word(24'sh7F_FFFF, 1'b0);
        push_word(24'sh00_0000, 1'b1);
        wait_idle();

        // Random phases: stable filters, arbitrary coefficients, corner picks
        for (ph = 0; ph < 6; ph++)
        begin
            calm = (ph == 3);
            case (ph % 3)
                0: load_coefs(int'($urandom_range(0, 32'h4000_0000)) - 32'sh2000_0000,
                              int'($urandom_range(0, 32'h4000_0000)) - 32'sh2000_0000,
                              int'($urandom_range(0, 32'h4000_0000)) - 32'sh2000_0000,
                              int'($urandom_range(0, 32'h2000_0000)) - 32'sh1000_0000,
                              $urandom_range(0, 32'h0800_0000));
                1: load_coefs($urandom, $urandom, $urandom, $urandom, $urandom);
                default: load_coefs(corner_coef(), corner_coef(), corner_coef(),
                                    corner_coef(), corner_coef());
            endcase
            if ($urandom_range(0, 1))
                write_reg(bqs_pkg::CFG_IDX_W'($urandom_range(5, 7)), $urandom);
            for (k = 0; k < 150; k++)
                push_word(rand_sample(), 1'($urandom));
            wait_idle();
        end

        repeat (20) @(posedge clk);
        $display("Checked %0d filtered words over %0d coefficient settings", checked_total,
                 settings_used);
        $display("Output clipped %0d times, feedback state clipped %0d times", y_clips,
                 w_clips);
        if (error_count == 0 && filtered_q.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+rtl/core
rtl/core/bqs_pkg.sv
rtl/core/bqs_seq.sv
rtl/core/bqs_mac.sv
rtl/core/biquad_shelf_filter_df2.sv
rtl/core/bqs_checker.sv
tb/biquad_shelf_filter_df2_tb.sv
